[src/skvt_pkg.sv]
// Shared types and constants for the sorted key/value table.
// Used by skvt_front, skvt_engine and the top level; depends on nothing.
package skvt_pkg;

  localparam int CAPACITY    = 64;
  localparam int KEY_WIDTH   = 32;
  localparam int VALUE_WIDTH = 32;
  localparam int IDX_W       = $clog2(CAPACITY);
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  localparam int ENTRY_W     = KEY_WIDTH + VALUE_WIDTH;

  typedef enum logic [2:0] {
    OP_INSERT_NEW    = 3'd0,
    OP_SET_OR_INSERT = 3'd1,
    OP_SET_EXISTING  = 3'd2,
    OP_FIND          = 3'd3,
    OP_EXISTS        = 3'd4,
    OP_ERASE         = 3'd5,
    OP_UNUSED_KEY    = 3'd6,
    OP_CLEAR         = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EXISTS    = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef struct packed {
    logic [2:0]             opcode;
    logic [KEY_WIDTH-1:0]   key;
    logic [VALUE_WIDTH-1:0] value;
  } request_t;

  typedef struct packed {
    logic [1:0]             status;
    logic                   hit;
    logic [31:0]            value_out;
    logic [31:0]            key_out;
    logic [CNT_W-1:0]       entry_count;
  } result_t;

  typedef struct packed {
    op_t                    op;
    logic [KEY_WIDTH-1:0]   key;
    logic [VALUE_WIDTH-1:0] value;
  } cmd_t;

endpackage

[src/skvt_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module skvt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/skvt_front.sv]
// Front end: accepts requests, decodes the opcode and holds them in a two-entry queue.
// Depends on skvt_pkg.
module skvt_front
  import skvt_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  output logic     full,
  input  request_t request,
  output logic     cmd_valid,
  input  logic     cmd_take,
  output cmd_t     cmd
);

  cmd_t       slots [2];
  logic       wp;
  logic       rp;
  logic [1:0] cnt;
  logic       do_push;
  logic       do_pop;

  assign full      = (cnt == 2'd2);
  assign cmd_valid = (cnt != 2'd0);
  assign cmd       = slots[rp];
  assign do_push   = push && !full;
  assign do_pop    = cmd_take && cmd_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (do_push) begin
        wp <= ~wp;
      end
      if (do_pop) begin
        rp <= ~rp;
      end
      cnt <= cnt + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wp] <= '{op: op_t'(request.opcode), key: request.key, value: request.value};
    end
  end

endmodule

[src/skvt_engine.sv]
// Back end: binary search, entry shifting and key scan over the entry RAM.
// Depends on skvt_pkg and skvt_ram.
module skvt_engine
  import skvt_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    cmd_valid,
  output logic    cmd_take,
  input  cmd_t    cmd_in,
  output logic    res_valid,
  input  logic    res_ready,
  output result_t res
);

  typedef enum logic [10:0] {
    S_IDLE     = 11'b00000000001,
    S_LB_RD    = 11'b00000000010,
    S_LB_CMP   = 11'b00000000100,
    S_CHK_RD   = 11'b00000001000,
    S_CHK_CMP  = 11'b00000010000,
    S_SH_RD    = 11'b00000100000,
    S_SH_WR    = 11'b00001000000,
    S_INS      = 11'b00010000000,
    S_SCAN_RD  = 11'b00100000000,
    S_SCAN_CMP = 11'b01000000000,
    S_DONE     = 11'b10000000000
  } state_t;

  state_t                 state;
  cmd_t                   cmd;
  logic [CNT_W-1:0]       count;
  logic [CNT_W-1:0]       base;
  logic [CNT_W-1:0]       len;
  logic [CNT_W-1:0]       idx;
  logic [CNT_W-1:0]       ptr;
  status_t                r_status;
  logic                   r_hit;
  logic [31:0]            r_vout;
  logic [31:0]            r_kout;

  logic                   we;
  logic [IDX_W-1:0]       waddr;
  logic [ENTRY_W-1:0]     wdata;
  logic [IDX_W-1:0]       raddr;
  logic [ENTRY_W-1:0]     rdata;
  logic [KEY_WIDTH-1:0]   rkey;
  logic [VALUE_WIDTH-1:0] rval;
  logic [CNT_W-1:0]       mid;
  logic                   present;
  logic                   is_insert;

  assign rkey      = rdata[ENTRY_W-1:VALUE_WIDTH];
  assign rval      = rdata[VALUE_WIDTH-1:0];
  assign mid       = base + (len >> 1);
  assign present   = (idx < count) && (rkey == cmd.key);
  assign is_insert = (cmd.op == OP_INSERT_NEW) || (cmd.op == OP_SET_OR_INSERT);
  assign cmd_take  = (state == S_IDLE) && cmd_valid;
  assign res_valid = (state == S_DONE);
  assign res       = '{status: r_status, hit: r_hit, value_out: r_vout,
                       key_out: r_kout, entry_count: count};

  skvt_ram #(.WIDTH(ENTRY_W), .DEPTH(CAPACITY)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    we    = 1'b0;
    waddr = idx[IDX_W-1:0];
    wdata = {cmd.key, cmd.value};
    raddr = ptr[IDX_W-1:0];
    unique case (state)
      S_LB_RD, S_LB_CMP: raddr = mid[IDX_W-1:0];
      S_CHK_RD: raddr = idx[IDX_W-1:0];
      S_CHK_CMP: begin
        if (present && (cmd.op == OP_SET_OR_INSERT || cmd.op == OP_SET_EXISTING)) begin
          we = 1'b1;
        end else if (!present && is_insert && count != CNT_W'(CAPACITY) && idx == count) begin
          we = 1'b1;
        end
      end
      S_SH_WR: begin
        we    = 1'b1;
        wdata = rdata;
        if (is_insert) begin
          waddr = IDX_W'(ptr + 1'b1);
        end else begin
          waddr = IDX_W'(ptr - 1'b1);
        end
      end
      S_INS: we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            cmd      <= cmd_in;
            base     <= '0;
            len      <= count;
            r_status <= ST_OK;
            r_hit    <= 1'b0;
            r_vout   <= '0;
            r_kout   <= '0;
            if (cmd_in.op == OP_CLEAR) begin
              count <= '0;
              state <= S_DONE;
            end else begin
              state <= S_LB_RD;
            end
          end
        end
        S_LB_RD: begin
          if (len == '0) begin
            idx   <= base;
            state <= S_CHK_RD;
          end else begin
            state <= S_LB_CMP;
          end
        end
        S_LB_CMP: begin
          if (rkey < cmd.key) begin
            base <= mid + 1'b1;
            len  <= len - (len >> 1) - 1'b1;
          end else begin
            len <= len >> 1;
          end
          state <= S_LB_RD;
        end
        S_CHK_RD: state <= S_CHK_CMP;
        S_CHK_CMP: begin
          state <= S_DONE;
          unique case (cmd.op)
            OP_INSERT_NEW, OP_SET_OR_INSERT: begin
              if (present) begin
                r_hit <= 1'b1;
                if (cmd.op == OP_INSERT_NEW) begin
                  r_status <= ST_EXISTS;
                end
              end else if (count == CNT_W'(CAPACITY)) begin
                r_status <= ST_FULL;
              end else if (idx == count) begin
                count <= count + 1'b1;
              end else begin
                ptr   <= count - 1'b1;
                state <= S_SH_RD;
              end
            end
            OP_SET_EXISTING: begin
              r_hit <= present;
              if (!present) begin
                r_status <= ST_NOT_FOUND;
              end
            end
            OP_FIND: begin
              r_hit <= present;
              if (present) begin
                r_vout <= 32'(rval);
              end else begin
                r_status <= ST_NOT_FOUND;
              end
            end
            OP_EXISTS: r_hit <= present;
            OP_ERASE: begin
              if (present) begin
                r_hit <= 1'b1;
                if (idx + 1'b1 < count) begin
                  ptr   <= idx + 1'b1;
                  state <= S_SH_RD;
                end else begin
                  count <= count - 1'b1;
                end
              end else begin
                r_status <= ST_NOT_FOUND;
              end
            end
            OP_UNUSED_KEY: begin
              ptr   <= '0;
              state <= S_SCAN_RD;
            end
            OP_CLEAR: count <= '0;
          endcase
        end
        S_SH_RD: state <= S_SH_WR;
        S_SH_WR: begin
          if (is_insert) begin
            if (ptr == idx) begin
              state <= S_INS;
            end else begin
              ptr   <= ptr - 1'b1;
              state <= S_SH_RD;
            end
          end else begin
            if (ptr + 1'b1 == count) begin
              count <= count - 1'b1;
              state <= S_DONE;
            end else begin
              ptr   <= ptr + 1'b1;
              state <= S_SH_RD;
            end
          end
        end
        S_INS: begin
          count <= count + 1'b1;
          state <= S_DONE;
        end
        S_SCAN_RD: begin
          if (ptr == count) begin
            r_kout <= 32'(ptr);
            state  <= S_DONE;
          end else begin
            state <= S_SCAN_CMP;
          end
        end
        S_SCAN_CMP: begin
          if (rkey != KEY_WIDTH'(ptr)) begin
            r_kout <= 32'(ptr);
            state  <= S_DONE;
          end else begin
            ptr   <= ptr + 1'b1;
            state <= S_SCAN_RD;
          end
        end
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[src/sorted_key_value_table.sv]
// Top level of the sorted key/value table: request queue, engine and result register.
// Depends on skvt_pkg, skvt_front and skvt_engine.
//
// Requests enter through a queue interface: a request is taken at a clock edge
// with push high and full low. Two requests can wait ahead of the engine.
// Results leave through a queue interface: while empty is low the oldest result
// is on the result port, and it is taken at an edge with pop high.
// Every request gives exactly one result, in request order.
// The engine runs a binary search over the filled entries, one probe at a
// time on the registered-read entry RAM (up to 7 probes), then a presence
// check. An insert that moves entries shifts each one up a place, from the
// top down, and then writes the new entry; an erase shifts each entry above
// the erased one down a place. The unused-key scan examines entries in order
// and stops at the first whose key differs from its index, or at the end of
// the table. Clear empties the table without touching the entry RAM.
// Reset empties the table and both queues; no clearing pass is needed.
// When the receiver stalls, one result waits in the output register, the
// engine holds its next result, and requests back up until full rises.
module sorted_key_value_table
  import skvt_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  output logic     full,
  input  request_t request,
  output logic     empty,
  input  logic     pop,
  output result_t  result
);

  logic    cmd_valid;
  logic    cmd_take;
  cmd_t    cmd;
  logic    res_valid;
  logic    res_ready;
  result_t res;
  logic    out_valid;

  skvt_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .request   (request),
    .cmd_valid (cmd_valid),
    .cmd_take  (cmd_take),
    .cmd       (cmd)
  );

  skvt_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_take  (cmd_take),
    .cmd_in    (cmd),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  assign empty     = !out_valid;
  assign res_ready = !out_valid || pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      result <= res;
    end
  end

endmodule
